[design/assert_macros.svh]
// assertion helpers, compiled out when ASSERT_OFF is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// property holds in the same cycle
`define ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// property holds in the next cycle
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_NOW(lbl, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

[design/mcbf_pkg.sv]
package mcbf_pkg;

   localparam int NUM_CHANNELS = 8;
   localparam int QUEUE_DEPTH  = 16;
   localparam int WORD_BITS    = 32;

   localparam int CH_IDX_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int POS_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
   localparam int SUM_W     = CNT_W + 1;
   localparam int STORE_DEPTH = NUM_CHANNELS * QUEUE_DEPTH;
   localparam int ADDR_W    = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

   localparam int OPCODE_W  = 3;
   localparam int CHAN_W    = 3;
   localparam int PORT_WORD_W = 32;
   localparam int LIMIT_W   = 5;
   localparam int STATUS_W  = 2;

   typedef enum logic [OPCODE_W-1:0] {
      OP_OPEN      = 3'd0,
      OP_CLOSE     = 3'd1,
      OP_SEND      = 3'd2,
      OP_RECEIVE   = 3'd3,
      OP_BROADCAST = 3'd4
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK          = 2'd0,
      ST_NO_CHANNEL  = 2'd1,
      ST_WOULD_BLOCK = 2'd2,
      ST_NO_SLOT     = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN_OPEN,
      S_CHECK,
      S_READ_WAIT,
      S_SCAN_FULL,
      S_PUSH_ALL,
      S_DONE
   } seq_state_type;

   typedef enum logic [2:0] {
      SC_NONE,
      SC_OPEN,
      SC_CLOSE,
      SC_PUSH,
      SC_POP
   } slot_op_type;

   typedef struct packed {
      logic [OPCODE_W-1:0]    opcode;
      logic [CHAN_W-1:0]      channel;
      logic [PORT_WORD_W-1:0] word;
      logic [LIMIT_W-1:0]     limit;
   } req_type;

   typedef struct packed {
      slot_op_type         kind;
      logic [CH_IDX_W-1:0] idx;
      logic [CNT_W-1:0]    limit;
   } slot_cmd_type;

   typedef struct packed {
      logic              is_open;
      logic              is_full;
      logic              is_empty;
      logic [ADDR_W-1:0] wr_addr;
      logic [ADDR_W-1:0] rd_addr;
   } slot_info_type;

   typedef struct packed {
      logic                 wr_en;
      logic                 rd_en;
      logic [ADDR_W-1:0]    wr_addr;
      logic [ADDR_W-1:0]    rd_addr;
      logic [WORD_BITS-1:0] wr_data;
   } mem_req_type;

   typedef struct packed {
      logic                   valid;
      status_type             status;
      logic [CHAN_W-1:0]      chan;
      logic [PORT_WORD_W-1:0] word;
   } result_type;

   // capacity requested on open, clipped to the ring size
   function automatic logic [CNT_W-1:0] sat_limit(input logic [LIMIT_W-1:0] lim);
      logic [CNT_W-1:0] r;
      if (32'(lim) > 32'(QUEUE_DEPTH)) r = CNT_W'(QUEUE_DEPTH);
      else r = CNT_W'(lim);
      return r;
   endfunction

endpackage

[design/mcbf_ram.sv]
module mcbf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[design/mcbf_slot_unit.sv]
module mcbf_slot_unit (
   input  logic                   clock,
   input  logic                   reset,
   input  mcbf_pkg::slot_cmd_type cmd,
   output mcbf_pkg::slot_info_type info
);

   logic                         open_ff  [mcbf_pkg::NUM_CHANNELS];
   logic                         open_in  [mcbf_pkg::NUM_CHANNELS];
   logic [mcbf_pkg::CNT_W-1:0]   limit_ff [mcbf_pkg::NUM_CHANNELS];
   logic [mcbf_pkg::CNT_W-1:0]   limit_in [mcbf_pkg::NUM_CHANNELS];
   logic [mcbf_pkg::POS_W-1:0]   head_ff  [mcbf_pkg::NUM_CHANNELS];
   logic [mcbf_pkg::POS_W-1:0]   head_in  [mcbf_pkg::NUM_CHANNELS];
   logic [mcbf_pkg::CNT_W-1:0]   fill_ff  [mcbf_pkg::NUM_CHANNELS];
   logic [mcbf_pkg::CNT_W-1:0]   fill_in  [mcbf_pkg::NUM_CHANNELS];

   logic [mcbf_pkg::POS_W-1:0]   cur_head;
   logic [mcbf_pkg::CNT_W-1:0]   cur_fill;
   logic [mcbf_pkg::SUM_W-1:0]   tail_sum;
   logic [mcbf_pkg::POS_W-1:0]   tail_pos;
   logic [mcbf_pkg::ADDR_W-1:0]  base_addr;

   // shared compare and address unit, looks at one slot at a time
   always_comb begin
      cur_head = head_ff[cmd.idx];
      cur_fill = fill_ff[cmd.idx];
      tail_sum = mcbf_pkg::SUM_W'(cur_head) + mcbf_pkg::SUM_W'(cur_fill);
      if (tail_sum >= mcbf_pkg::SUM_W'(mcbf_pkg::QUEUE_DEPTH)) begin
         tail_pos = mcbf_pkg::POS_W'(tail_sum - mcbf_pkg::SUM_W'(mcbf_pkg::QUEUE_DEPTH));
      end else begin
         tail_pos = mcbf_pkg::POS_W'(tail_sum);
      end
      base_addr = mcbf_pkg::ADDR_W'(cmd.idx) * mcbf_pkg::ADDR_W'(mcbf_pkg::QUEUE_DEPTH);
      info.is_open  = open_ff[cmd.idx];
      info.is_full  = cur_fill >= limit_ff[cmd.idx];
      info.is_empty = cur_fill == '0;
      info.wr_addr  = base_addr + mcbf_pkg::ADDR_W'(tail_pos);
      info.rd_addr  = base_addr + mcbf_pkg::ADDR_W'(cur_head);
   end

   always_comb begin
      open_in  = open_ff;
      limit_in = limit_ff;
      head_in  = head_ff;
      fill_in  = fill_ff;
      unique case (cmd.kind)
         mcbf_pkg::SC_OPEN: begin
            open_in[cmd.idx]  = 1'b1;
            limit_in[cmd.idx] = cmd.limit;
            head_in[cmd.idx]  = '0;
            fill_in[cmd.idx]  = '0;
         end
         mcbf_pkg::SC_CLOSE: begin
            open_in[cmd.idx]  = 1'b0;
            limit_in[cmd.idx] = '0;
            head_in[cmd.idx]  = '0;
            fill_in[cmd.idx]  = '0;
         end
         mcbf_pkg::SC_PUSH: begin
            fill_in[cmd.idx] = cur_fill + 1'b1;
         end
         mcbf_pkg::SC_POP: begin
            fill_in[cmd.idx] = cur_fill - 1'b1;
            if (cur_head == mcbf_pkg::POS_W'(mcbf_pkg::QUEUE_DEPTH - 1)) begin
               head_in[cmd.idx] = '0;
            end else begin
               head_in[cmd.idx] = cur_head + 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < mcbf_pkg::NUM_CHANNELS; i++) begin
            open_ff[i]  <= 1'b0;
            limit_ff[i] <= '0;
            head_ff[i]  <= '0;
            fill_ff[i]  <= '0;
         end
      end else begin
         open_ff  <= open_in;
         limit_ff <= limit_in;
         head_ff  <= head_in;
         fill_ff  <= fill_in;
      end
   end

endmodule

[design/mcbf_seq.sv]
module mcbf_seq (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  mcbf_pkg::req_type                 req,
   output logic                              busy,
   input  mcbf_pkg::slot_info_type           info,
   output mcbf_pkg::slot_cmd_type            cmd,
   output mcbf_pkg::mem_req_type             mem,
   input  logic [mcbf_pkg::WORD_BITS-1:0]    mem_rd_data,
   output mcbf_pkg::result_type              res,
   input  logic                              res_take
);

   mcbf_pkg::seq_state_type state_ff, state_in;
   mcbf_pkg::opcode_type    op_ff, op_in;
   logic [mcbf_pkg::CH_IDX_W-1:0]    cur_ff, cur_in;
   logic                             in_range_ff, in_range_in;
   logic [mcbf_pkg::WORD_BITS-1:0]   word_ff, word_in;
   logic [mcbf_pkg::CNT_W-1:0]       lim_ff, lim_in;
   logic                             any_ff, any_in;
   logic                             full_ff, full_in;
   mcbf_pkg::status_type             status_ff, status_in;
   logic [mcbf_pkg::CHAN_W-1:0]      chan_ff, chan_in;
   logic [mcbf_pkg::PORT_WORD_W-1:0] rword_ff, rword_in;

   logic last_slot;
   logic any_now;
   logic full_now;

   assign last_slot = cur_ff == mcbf_pkg::CH_IDX_W'(mcbf_pkg::NUM_CHANNELS - 1);
   assign any_now   = any_ff | info.is_open;
   assign full_now  = full_ff | (info.is_open & info.is_full);
   assign busy      = state_ff != mcbf_pkg::S_IDLE;

   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      cur_in      = cur_ff;
      in_range_in = in_range_ff;
      word_in     = word_ff;
      lim_in      = lim_ff;
      any_in      = any_ff;
      full_in     = full_ff;
      status_in   = status_ff;
      chan_in     = chan_ff;
      rword_in    = rword_ff;

      cmd.kind  = mcbf_pkg::SC_NONE;
      cmd.idx   = cur_ff;
      cmd.limit = lim_ff;

      mem.wr_en   = 1'b0;
      mem.rd_en   = 1'b0;
      mem.wr_addr = info.wr_addr;
      mem.rd_addr = info.rd_addr;
      mem.wr_data = word_ff;

      res.valid  = state_ff == mcbf_pkg::S_DONE;
      res.status = status_ff;
      res.chan   = chan_ff;
      res.word   = rword_ff;

      unique case (state_ff)
         mcbf_pkg::S_IDLE: begin
            if (req_valid) begin
               op_in       = mcbf_pkg::opcode_type'(req.opcode);
               word_in     = mcbf_pkg::WORD_BITS'(req.word);
               lim_in      = mcbf_pkg::sat_limit(req.limit);
               in_range_in = 32'(req.channel) < 32'(mcbf_pkg::NUM_CHANNELS);
               cur_in      = mcbf_pkg::CH_IDX_W'(req.channel);
               any_in      = 1'b0;
               full_in     = 1'b0;
               status_in   = mcbf_pkg::ST_NO_CHANNEL;
               chan_in     = '0;
               rword_in    = '0;
               unique case (mcbf_pkg::opcode_type'(req.opcode))
                  mcbf_pkg::OP_OPEN: begin
                     cur_in   = '0;
                     state_in = mcbf_pkg::S_SCAN_OPEN;
                  end
                  mcbf_pkg::OP_CLOSE,
                  mcbf_pkg::OP_SEND,
                  mcbf_pkg::OP_RECEIVE: begin
                     state_in = mcbf_pkg::S_CHECK;
                  end
                  mcbf_pkg::OP_BROADCAST: begin
                     cur_in   = '0;
                     state_in = mcbf_pkg::S_SCAN_FULL;
                  end
                  default: begin
                     state_in = mcbf_pkg::S_DONE;
                  end
               endcase
            end
         end

         // lowest free slot wins
         mcbf_pkg::S_SCAN_OPEN: begin
            if (!info.is_open) begin
               cmd.kind  = mcbf_pkg::SC_OPEN;
               status_in = mcbf_pkg::ST_OK;
               chan_in   = mcbf_pkg::CHAN_W'(cur_ff);
               state_in  = mcbf_pkg::S_DONE;
            end else if (last_slot) begin
               status_in = mcbf_pkg::ST_NO_SLOT;
               state_in  = mcbf_pkg::S_DONE;
            end else begin
               cur_in = cur_ff + 1'b1;
            end
         end

         mcbf_pkg::S_CHECK: begin
            state_in = mcbf_pkg::S_DONE;
            if (in_range_ff && info.is_open) begin
               unique case (op_ff)
                  mcbf_pkg::OP_CLOSE: begin
                     cmd.kind  = mcbf_pkg::SC_CLOSE;
                     status_in = mcbf_pkg::ST_OK;
                  end
                  mcbf_pkg::OP_SEND: begin
                     if (info.is_full) begin
                        status_in = mcbf_pkg::ST_WOULD_BLOCK;
                     end else begin
                        mem.wr_en = 1'b1;
                        cmd.kind  = mcbf_pkg::SC_PUSH;
                        status_in = mcbf_pkg::ST_OK;
                     end
                  end
                  mcbf_pkg::OP_RECEIVE: begin
                     if (info.is_empty) begin
                        status_in = mcbf_pkg::ST_WOULD_BLOCK;
                     end else begin
                        mem.rd_en = 1'b1;
                        cmd.kind  = mcbf_pkg::SC_POP;
                        status_in = mcbf_pkg::ST_OK;
                        state_in  = mcbf_pkg::S_READ_WAIT;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         mcbf_pkg::S_READ_WAIT: begin
            rword_in = mcbf_pkg::PORT_WORD_W'(mem_rd_data);
            state_in = mcbf_pkg::S_DONE;
         end

         // first pass: any open slot, any full slot
         mcbf_pkg::S_SCAN_FULL: begin
            any_in  = any_now;
            full_in = full_now;
            if (last_slot) begin
               cur_in = '0;
               if (!any_now) begin
                  status_in = mcbf_pkg::ST_NO_CHANNEL;
                  state_in  = mcbf_pkg::S_DONE;
               end else if (full_now) begin
                  status_in = mcbf_pkg::ST_WOULD_BLOCK;
                  state_in  = mcbf_pkg::S_DONE;
               end else begin
                  state_in = mcbf_pkg::S_PUSH_ALL;
               end
            end else begin
               cur_in = cur_ff + 1'b1;
            end
         end

         // second pass: one store write per open slot
         mcbf_pkg::S_PUSH_ALL: begin
            if (info.is_open) begin
               mem.wr_en = 1'b1;
               cmd.kind  = mcbf_pkg::SC_PUSH;
            end
            if (last_slot) begin
               status_in = mcbf_pkg::ST_OK;
               state_in  = mcbf_pkg::S_DONE;
            end else begin
               cur_in = cur_ff + 1'b1;
            end
         end

         mcbf_pkg::S_DONE: begin
            if (res_take) begin
               state_in = mcbf_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = mcbf_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mcbf_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      cur_ff      <= cur_in;
      in_range_ff <= in_range_in;
      word_ff     <= word_in;
      lim_ff      <= lim_in;
      any_ff      <= any_in;
      full_ff     <= full_in;
      status_ff   <= status_in;
      chan_ff     <= chan_in;
      rword_ff    <= rword_in;
   end

endmodule

[design/multi_channel_bounded_fifo.sv]
// Eight bounded word queues behind one operation port. Each request beat carries an
// opcode (open, close, send, receive, broadcast) and gets exactly one response beat
// with a status (ok, no channel, would block, no free slot), the slot number that an
// open handed out and the word that a receive popped. The block works on one request
// at a time and holds req_stall high from the beat after acceptance until the response
// is moved into the output register; that register lets the next request in while a
// response still waits on rsp_stall. From acceptance to the response register, an
// unknown opcode goes straight to the done state; close, send and a refused receive
// pass through the check state; a receive that pops also waits for the registered
// store read; open scans for the lowest free slot; broadcast makes a check pass over
// all slots and, when it is delivered, then one store write per open slot. A full and
// stalled response register holds a finished result back. A single sequencer steps a
// slot index over the per-slot tables, and a single store write or read port sets the
// per-slot pace. No clearing pass is needed after reset: the store is only read where a
// word was written.
`include "assert_macros.svh"

module multi_channel_bounded_fifo (
   input  logic        clock,
   input  logic        reset,

   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_opcode,
   input  logic [2:0]  req_channel,
   input  logic [31:0] req_word_in,
   input  logic [4:0]  req_limit,

   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [2:0]  rsp_channel_out,
   output logic [31:0] rsp_word_out
);

   mcbf_pkg::req_type       req;
   mcbf_pkg::slot_cmd_type  cmd;
   mcbf_pkg::slot_info_type info;
   mcbf_pkg::mem_req_type   mem;
   mcbf_pkg::result_type    res;
   logic [mcbf_pkg::WORD_BITS-1:0] mem_rd_data;
   logic seq_busy;
   logic res_take;

   // output register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  status_ff, status_in;
   logic [2:0]  chan_ff, chan_in;
   logic [31:0] word_ff, word_in;

   assign req.opcode  = req_opcode;
   assign req.channel = req_channel;
   assign req.word    = req_word_in;
   assign req.limit   = req_limit;

   // busy sequencer blocks new requests
   assign req_stall = seq_busy;

   mcbf_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req         (req),
      .busy        (seq_busy),
      .info        (info),
      .cmd         (cmd),
      .mem         (mem),
      .mem_rd_data (mem_rd_data),
      .res         (res),
      .res_take    (res_take)
   );

   // per-slot open flag, limit, head and fill, plus the shared compare/address logic
   mcbf_slot_unit u_slots (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .info  (info)
   );

   // ring storage, one row of QUEUE_DEPTH words per slot
   mcbf_ram #(
      .WIDTH (mcbf_pkg::WORD_BITS),
      .DEPTH (mcbf_pkg::STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem.wr_en),
      .wr_addr (mem.wr_addr),
      .wr_data (mem.wr_data),
      .rd_en   (mem.rd_en),
      .rd_addr (mem.rd_addr),
      .rd_data (mem_rd_data)
   );

   // a finished result moves over when the output register is empty or draining
   assign res_take = res.valid && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      status_in    = status_ff;
      chan_in      = chan_ff;
      word_in      = word_ff;
      if (res_take) begin
         rsp_valid_in = 1'b1;
         status_in    = res.status;
         chan_in      = res.chan;
         word_in      = res.word;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      chan_ff   <= chan_in;
      word_ff   <= word_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_channel_out = chan_ff;
   assign rsp_word_out    = word_ff;

   // an accepted request keeps the sequencer busy for at least the next cycle
   `ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall,
                "sequencer not busy after accept")
   // an idle sequencer holds no pending result
   `ASSERT_NOW(a_idle_no_result, clock, reset, !req_stall, !res.valid,
               "result pending while idle")
   // only a successful operation carries a slot number or a word
   `ASSERT_NOW(a_fail_clean, clock, reset, rsp_valid && rsp_status != mcbf_pkg::ST_OK,
               rsp_channel_out == 3'd0 && rsp_word_out == 32'd0,
               "failed response carries data")

endmodule
